@@ sv/mvt_pkg.sv @@
package mvt_pkg;

  localparam int ROWS         = 4;
  localparam int COLS         = 4;
  localparam int COEF_INDEX_W = 4;

  // tuser code that tells a load word from a transform word
  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_XFORM = 1'b1
  } op_t;

endpackage

@@ sv/mvt_mult.sv @@
// One signed DATA_WIDTH x DATA_WIDTH product, split over two stages:
// two half-width partial products, then the shifted combine.
module mvt_mult #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [DATA_WIDTH-1:0]  coef,
  input  logic signed [DATA_WIDTH-1:0]  vec,
  output logic signed [2*DATA_WIDTH-1:0] prod
);
  import mvt_pkg::*;

  localparam int LO_W   = DATA_WIDTH / 2;
  localparam int HI_W   = DATA_WIDTH - LO_W;
  localparam int PL_W   = DATA_WIDTH + LO_W + 1;
  localparam int PH_W   = DATA_WIDTH + HI_W;
  localparam int PROD_W = 2 * DATA_WIDTH;

  logic signed [LO_W:0]        vec_lo;
  logic signed [HI_W-1:0]      vec_hi;
  logic signed [PL_W-1:0]      pp_lo_next;
  logic signed [PH_W-1:0]      pp_hi_next;
  logic signed [PL_W-1:0]      pp_lo;
  logic signed [PH_W-1:0]      pp_hi;
  logic signed [PROD_W-1:0]    prod_next;

  // low half is unsigned, high half carries the sign
  assign vec_lo     = $signed({1'b0, vec[LO_W-1:0]});
  assign vec_hi     = vec[DATA_WIDTH-1:LO_W];
  assign pp_lo_next = coef * vec_lo;
  assign pp_hi_next = coef * vec_hi;

  assign prod_next = (PROD_W'(pp_hi) <<< LO_W) + PROD_W'(pp_lo);

  always_ff @(posedge clk) begin
    if (en) begin
      pp_lo <= pp_lo_next;
      pp_hi <= pp_hi_next;
      prod  <= prod_next;
    end
  end

endmodule

@@ sv/mvt_row.sv @@
// Row dot product back end: pair sums, row sum, then shift and saturate
// into the output register.
module mvt_row #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                           clk,
  input  logic                           en,
  input  logic signed [2*DATA_WIDTH-1:0] prod [mvt_pkg::COLS],
  output logic signed [DATA_WIDTH-1:0]   result
);
  import mvt_pkg::*;

  localparam int PROD_W = 2 * DATA_WIDTH;
  localparam int PAIR_W = PROD_W + 1;
  localparam int SUM_W  = PROD_W + 2;

  logic signed [PAIR_W-1:0]     pair_a;
  logic signed [PAIR_W-1:0]     pair_b;
  logic signed [SUM_W-1:0]      sum;
  logic signed [SUM_W-1:0]      shifted;
  logic signed [SUM_W-1:0]      max_v;
  logic signed [SUM_W-1:0]      min_v;
  logic signed [DATA_WIDTH-1:0] result_next;

  assign max_v = {{(SUM_W-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
  assign min_v = {{(SUM_W-DATA_WIDTH+1){1'b1}}, {(DATA_WIDTH-1){1'b0}}};

  // arithmetic shift floors toward minus infinity
  assign shifted = sum >>> FRAC_BITS;

  always_comb begin
    if (shifted > max_v) begin
      result_next = max_v[DATA_WIDTH-1:0];
    end else if (shifted < min_v) begin
      result_next = min_v[DATA_WIDTH-1:0];
    end else begin
      result_next = shifted[DATA_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pair_a <= PAIR_W'(prod[0]) + PAIR_W'(prod[1]);
      pair_b <= PAIR_W'(prod[COLS-2]) + PAIR_W'(prod[COLS-1]);
      sum    <= SUM_W'(pair_a) + SUM_W'(pair_b);
      result <= result_next;
    end
  end

endmodule

@@ sv/matrix_vector_transform_4x4_top.sv @@
// 4x4 matrix by vector transform, signed fixed point (FRAC_BITS fraction
// bits, DATA_WIDTH bits per value). A load word (tuser = 0) writes one of
// the 16 coefficients, addressed row*4+column, and returns nothing; the
// store is cleared to zero by reset. A transform word (tuser = 1) returns
// one word with four components, each the exact sum of a row's four
// products, floored by FRAC_BITS and saturated to DATA_WIDTH bits.
// Throughput is one word per clock unless the output stalls; a transform result
// passes the input register, two multiplier stages, two adder stages and the
// output register. Sixteen multiplier lanes and four adder trees make up the
// datapath. The whole pipeline advances together and stops only while the
// output word waits with m_tready low.
module matrix_vector_transform_4x4_top #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic clk,
  input  logic rst,

  input  logic s_tvalid,
  output logic s_tready,
  // coef_index, coef_value, vec_x, vec_y, vec_z, vec_w (low bit up)
  input  logic [((mvt_pkg::COEF_INDEX_W+5*DATA_WIDTH+7)/8)*8-1:0] s_tdata,
  // op
  input  logic s_tuser,

  output logic m_tvalid,
  input  logic m_tready,
  // out_x, out_y, out_z, out_w (low bit up)
  output logic [((mvt_pkg::ROWS*DATA_WIDTH+7)/8)*8-1:0] m_tdata
);
  import mvt_pkg::*;

  localparam int PIPE_DEPTH = 6;
  localparam int ENTRIES    = ROWS * COLS;
  localparam int M_DATA_W   = ((ROWS*DATA_WIDTH+7)/8)*8;

  logic                          en;
  logic                          accept;
  logic [PIPE_DEPTH-1:0]         vld;
  logic [COEF_INDEX_W-1:0]       coef_index;
  logic signed [DATA_WIDTH-1:0]  coef_value;
  logic signed [DATA_WIDTH-1:0]  vec_in [COLS];
  logic signed [DATA_WIDTH-1:0]  vec_s1 [COLS];
  logic signed [DATA_WIDTH-1:0]  matrix [ENTRIES];
  logic signed [2*DATA_WIDTH-1:0] prod [ROWS][COLS];
  logic signed [DATA_WIDTH-1:0]  result [ROWS];

  // field unpack
  assign coef_index = s_tdata[COEF_INDEX_W-1:0];
  assign coef_value = s_tdata[COEF_INDEX_W +: DATA_WIDTH];
  for (genvar c = 0; c < COLS; c++) begin : g_unpack
    assign vec_in[c] = s_tdata[COEF_INDEX_W + (c+1)*DATA_WIDTH +: DATA_WIDTH];
  end

  // single pipeline enable: move unless the output word is stuck
  assign en       = !vld[PIPE_DEPTH-1] || m_tready;
  assign s_tready = en;
  assign accept   = s_tvalid && en;
  assign m_tvalid = vld[PIPE_DEPTH-1];

  // valid bits; only transform words occupy a slot
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[PIPE_DEPTH-2:0], accept && (op_t'(s_tuser) == OP_XFORM)};
    end
  end

  // coefficient store; a load lands before any later transform reads it
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ENTRIES; i++) begin
        matrix[i] <= '0;
      end
    end else if (accept && (op_t'(s_tuser) == OP_LOAD)) begin
      matrix[coef_index] <= coef_value;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < COLS; c++) begin
        vec_s1[c] <= vec_in[c];
      end
    end
  end

  for (genvar r = 0; r < ROWS; r++) begin : g_row
    for (genvar c = 0; c < COLS; c++) begin : g_col
      mvt_mult #(
        .DATA_WIDTH (DATA_WIDTH)
      ) u_mult (
        .clk  (clk),
        .en   (en),
        .coef (matrix[r*COLS+c]),
        .vec  (vec_s1[c]),
        .prod (prod[r][c])
      );
    end

    mvt_row #(
      .DATA_WIDTH (DATA_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
    ) u_row (
      .clk    (clk),
      .en     (en),
      .prod   (prod[r]),
      .result (result[r])
    );

    assign m_tdata[r*DATA_WIDTH +: DATA_WIDTH] = result[r];
  end

  if (M_DATA_W > ROWS*DATA_WIDTH) begin : g_pad
    assign m_tdata[M_DATA_W-1:ROWS*DATA_WIDTH] = '0;
  end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

  import mvt_pkg::*;

  localparam int DW      = 32;
  localparam int FB      = 16;
  localparam int S_DATA_W = ((COEF_INDEX_W + 5 * DW + 7) / 8) * 8;
  localparam int M_DATA_W = ((ROWS * DW + 7) / 8) * 8;
  localparam int TAIL_CYCLES = 12;   // six-stage pipe plus margin
  localparam int RANDOM_WORDS = 2000;

  localparam logic signed [DW+33:0] SUM_MAX = {{35{1'b0}}, {31{1'b1}}};
  localparam logic signed [DW+33:0] SUM_MIN = {{35{1'b1}}, {31{1'b0}}};

  // one stimulus word plus the idle cycles placed ahead of it
  typedef struct {
    op_t                    op;
    logic [3:0]             idx;
    logic [DW-1:0]          coef;
    logic [3:0][DW-1:0]     vec;     // [0] = x ... [3] = w
    int unsigned            gap;
  } word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                s_tvalid = 1'b0;
  logic                s_tready;
  // coef_index, coef_value, vec_x, vec_y, vec_z, vec_w (low bit up)
  logic [S_DATA_W-1:0] s_tdata = '0;
  // op
  logic                s_tuser = 1'b0;

  logic                m_tvalid;
  logic                m_tready = 1'b0;
  // out_x, out_y, out_z, out_w (low bit up)
  logic [M_DATA_W-1:0] m_tdata;

  word_t               pending_words[$];
  word_t               cur_word;
  logic [DW-1:0]       coef_store[16];
  logic [M_DATA_W-1:0] xform_results_due[$];
  logic [M_DATA_W-1:0] due_word;

  int unsigned errors      = 0;
  int unsigned loads_taken = 0;
  int unsigned xforms_taken = 0;
  int unsigned results_seen = 0;
  int unsigned saturated   = 0;
  int unsigned sink_hold   = 0;
  int unsigned total_words = 0;
  string       comp_name[4] = '{"out_x", "out_y", "out_z", "out_w"};

  matrix_vector_transform_4x4_top #(
    .DATA_WIDTH(DW),
    .FRAC_BITS (FB)
  ) uut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  always #10 clk = ~clk;

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    errors++;
  endtask

  // exact row sum, floor by FB, clamp to DW bits
  function automatic logic [DW-1:0] row_dot(input int r, input logic [3:0][DW-1:0] v);
    logic signed [DW+33:0] acc;
    logic signed [2*DW-1:0] prod;
    acc = '0;
    for (int c = 0; c < COLS; c++) begin
      prod = $signed(coef_store[r * COLS + c]) * $signed(v[c]);
      acc  = acc + prod;
    end
    acc = acc >>> FB;
    if (acc > SUM_MAX) begin
      saturated++;
      return SUM_MAX[DW-1:0];
    end
    if (acc < SUM_MIN) begin
      saturated++;
      return SUM_MIN[DW-1:0];
    end
    return acc[DW-1:0];
  endfunction

  // update the coefficient store or queue the transform result, in accept order
  task automatic track_word(input word_t w);
    logic [M_DATA_W-1:0] res;
    if (w.op == OP_LOAD) begin
      coef_store[w.idx] = w.coef;
      loads_taken++;
    end else begin
      res = '0;
      for (int r = 0; r < ROWS; r++) res[r*DW +: DW] = row_dot(r, w.vec);
      xform_results_due.push_back(res);
      xforms_taken++;
    end
  endtask

  // mostly edge values and small fixed-point numbers, some full-range noise
  function automatic logic [DW-1:0] pick_q();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 9))
      0:       return 32'h7fffffff;
      1:       return 32'h80000000;
      2:       return 32'h00000000;
      3:       return r[0] ? 32'h00010000 : 32'hffff0000;   // +/-1.0
      4, 5, 6: return {{12{r[19]}}, r[19:0]};               // about +/-8.0
      default: return r;
    endcase
  endfunction

  function automatic word_t mk_load(input logic [3:0] idx, input logic [DW-1:0] coef);
    word_t w;
    w.op   = OP_LOAD;
    w.idx  = idx;
    w.coef = coef;
    for (int c = 0; c < 4; c++) w.vec[c] = $urandom;       // ignored by a load
    w.gap  = $urandom_range(0, 3);
    return w;
  endfunction

  function automatic word_t mk_xform(input logic [DW-1:0] x, input logic [DW-1:0] y,
                                     input logic [DW-1:0] z, input logic [DW-1:0] wv);
    word_t w;
    w.op   = OP_XFORM;
    w.idx  = 4'($urandom);                                  // ignored by a transform
    w.coef = $urandom;
    w.vec  = {wv, z, y, x};
    w.gap  = $urandom_range(0, 3);
    return w;
  endfunction

  // driver: one nonblocking update of tvalid per edge
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) track_word(cur_word);
      if (!s_tvalid || s_tready) begin
        if (pending_words.size() > 0 && pending_words[0].gap > 0) begin
          pending_words[0].gap = pending_words[0].gap - 1;
          s_tvalid <= 1'b0;
        end else if (pending_words.size() > 0) begin
          cur_word = pending_words.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= {{(S_DATA_W - COEF_INDEX_W - 5 * DW){1'b0}},
                       cur_word.vec, cur_word.coef, cur_word.idx};
          s_tuser  <= cur_word.op;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each result word with the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (xform_results_due.size() == 0) begin
          report_mismatch($sformatf("result word %h with no transform pending", m_tdata));
        end else begin
          due_word = xform_results_due.pop_front();
          for (int r = 0; r < ROWS; r++)
            if (m_tdata[r*DW +: DW] !== due_word[r*DW +: DW])
              report_mismatch($sformatf("result %0d %s got %h want %h", results_seen,
                comp_name[r], m_tdata[r*DW +: DW], due_word[r*DW +: DW]));
        end
        // every fourth stretch of 100 results runs with the sink always ready
        sink_hold = (((results_seen / 100) % 4) == 3) ? 0 : $urandom_range(0, 3);
      end
      if (sink_hold > 0) begin
        sink_hold = sink_hold - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin
    word_t w;
    for (int i = 0; i < 16; i++) coef_store[i] = '0;

    // cleared store: any vector maps to zero
    pending_words.push_back(mk_xform(32'h7fffffff, 32'h80000000, 32'hffffffff, 32'h00010000));
    // row 0 all max, row 1 all min, row 2 max/min mix, row 3 = -1 LSB at col 0
    for (int c = 0; c < 4; c++) pending_words.push_back(mk_load(4'(c), 32'h7fffffff));
    for (int c = 0; c < 4; c++) pending_words.push_back(mk_load(4'(4 + c), 32'h80000000));
    for (int c = 0; c < 4; c++)
      pending_words.push_back(mk_load(4'(8 + c), c[0] ? 32'h80000000 : 32'h7fffffff));
    pending_words.push_back(mk_load(4'd12, 32'hffffffff));
    pending_words.push_back(mk_load(4'd15, 32'h00000000));
    // saturation both ways
    pending_words.push_back(mk_xform(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
    pending_words.push_back(mk_xform(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000));
    // -1 LSB before the shift floors to -1 in row 3
    pending_words.push_back(mk_xform(32'h00000001, 32'h0, 32'h0, 32'h0));
    pending_words.push_back(mk_xform(32'hffffffff, 32'h0, 32'h0, 32'h0));
    // back-to-back with no gaps: load then an immediate transform using it
    w = mk_load(4'd15, 32'h00010000);
    w.gap = 0;
    pending_words.push_back(w);
    w = mk_xform(32'h0, 32'h0, 32'h0, 32'h00030000);
    w.gap = 0;
    pending_words.push_back(w);

    // random part: loads and transforms mixed, some stretches with no gaps
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if ($urandom_range(0, 9) < 4)
        w = mk_load(4'($urandom_range(0, 15)), pick_q());
      else
        w = mk_xform(pick_q(), pick_q(), pick_q(), pick_q());
      if (((n / 120) % 4) == 3) w.gap = 0;
      pending_words.push_back(w);
    end
    total_words = pending_words.size();

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // every word taken and every predicted result checked
    while ((loads_taken + xforms_taken) < total_words || xform_results_due.size() > 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d coefficient loads and %0d transforms, %0d result words checked,",
             loads_taken, xforms_taken, results_seen);
    $display("%0d predicted components clamped at the range limits.", saturated);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // watchdog, far above the slowest legal run
  initial begin
    #5_000_000;
    $display("Timeout with %0d results still due", xform_results_due.size());
    $display("simulation failed");
    $finish;
  end

endmodule
